/* sv/adsrem_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package adsrem_pkg;

    localparam int BUF_AW       = 16;
    localparam int BUFFER_DEPTH = 1 << BUF_AW;
    localparam int CNT_W        = BUF_AW + 1;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 18;

    localparam logic [CFG_IW-1:0] CFG_SAMPLE_RATE = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_RELEASE     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_NOTE_ON     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_NOTE_OFF    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ONSET       = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_SETUP1    = 4'd1;
    localparam logic [OP_W-1:0] OP_SETUP2    = 4'd2;
    localparam logic [OP_W-1:0] OP_PEAK_INIT = 4'd3;
    localparam logic [OP_W-1:0] OP_ATK_INIT  = 4'd4;
    localparam logic [OP_W-1:0] OP_CALC1     = 4'd5;
    localparam logic [OP_W-1:0] OP_CALC2     = 4'd6;
    localparam logic [OP_W-1:0] OP_CALC3     = 4'd7;
    localparam logic [OP_W-1:0] OP_SUS_INIT  = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV_INIT  = 4'd9;
    localparam logic [OP_W-1:0] OP_DEC_INIT  = 4'd10;
    localparam logic [OP_W-1:0] OP_REL_INIT  = 4'd11;
    localparam logic [OP_W-1:0] OP_RUN       = 4'd12;
    localparam logic [OP_W-1:0] OP_DIV_RUN   = 4'd13;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd14;

    typedef struct packed {
        logic            accept;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic invalid;
        logic peak_zero;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* sv/adsrem_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module adsrem_dp import adsrem_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic [15:0]       i_sample,
    input  wire logic              i_last_sample,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [1:0]             o_status,
    output logic [15:0]            o_peak_level,
    output logic [15:0]            o_attack_samples,
    output logic                   o_sustain_seen,
    output logic [15:0]            o_sustain_level,
    output logic                   o_decay_seen,
    output logic [15:0]            o_decay_samples,
    output logic [16:0]            o_release_samples
);

    localparam logic [2:0] P_PEAK = 3'd0;
    localparam logic [2:0] P_ATK  = 3'd1;
    localparam logic [2:0] P_SUS  = 3'd2;
    localparam logic [2:0] P_DEC  = 3'd3;
    localparam logic [2:0] P_REL  = 3'd4;

    localparam logic [23:0] RECIP_50 = 24'd335545;
    localparam logic [23:0] RECIP_10 = 24'd1677722;
    localparam logic [17:0] RECIP_5  = 18'd209716;

    logic [15:0] mem [0:BUFFER_DEPTH-1];

    logic [17:0] r_fs;
    logic [15:0] r_coef, r_on, r_off, r_onset;
    logic [CNT_W-1:0] r_count, r_n;
    logic [15:0] r_env;
    logic        r_done, r_ph, r_o_valid;

    logic [15:0] r_rd;
    logic [CNT_W-1:0] r_i, r_lim, r_ss, r_se, r_pk, r_st, r_rs, r_re;
    logic [2:0]  r_pass;
    logic        r_invalid, r_gate, r_found, r_sus_seen, r_dec_seen;
    logic [11:0] r_fs50;
    logic [14:0] r_fs10;
    logic [15:0] r_peak, r_prev, r_margin, r_w2, r_sus, r_dec;
    logic [21:0] r_p97, r_tgt;
    logic [17:0] r_s4;
    logic [31:0] r_sum, r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [17:0] r_rem;
    logic [5:0]  r_dcnt;

    logic [1:0]  r_o_status;
    logic [15:0] r_o_peak, r_o_attack, r_o_sus, r_o_dec;
    logic        r_o_sus_seen, r_o_dec_seen;
    logic [16:0] r_o_rel;

    logic [15:0] mag, env_dec, n_env;
    logic [31:0] env_prod;
    logic        full;
    logic [21:0] e100;
    logic [41:0] p50, p10;
    logic [35:0] p5;
    logic [CNT_W-1:0] n_ss, se_raw, n_se, off_n, n_rs, n_m1;
    logic [15:0] w_min;
    logic [17:0] rem_sh;
    logic        out_ok;

    always_comb begin
        mag      = i_sample[15] ? 16'(~i_sample + 16'd1) : i_sample;
        env_prod = 32'(r_env) * 32'(r_coef);
        env_dec  = env_prod[31:16];
        n_env    = (mag > r_env) ? mag : env_dec;
        full     = r_count[BUF_AW];
        e100     = 22'(r_rd) * 22'd100;
        p50      = 42'(r_fs) * 42'(RECIP_50);
        p10      = 42'(r_fs) * 42'(RECIP_10);
        p5       = 36'({r_margin, 1'b0}) * 36'(RECIP_5);
        n_m1     = r_n - CNT_W'(1);
        n_ss     = (CNT_W'(r_onset) < n_m1) ? CNT_W'(r_onset) : n_m1;
        se_raw   = CNT_W'(r_off) + CNT_W'(r_fs50);
        n_se     = (se_raw > r_n) ? r_n : se_raw;
        off_n    = (CNT_W'(r_off) < r_n) ? CNT_W'(r_off) : r_n;
        n_rs     = (CNT_W'(r_off) < n_m1) ? CNT_W'(r_off) : n_m1;
        w_min    = (16'(r_fs10) < r_w2) ? 16'(r_fs10) : r_w2;
        rem_sh   = {r_rem[16:0], r_quo[31]};
        out_ok   = !r_invalid && (r_peak != 16'd0);
    end

    assign o_stat.done      = r_done;
    assign o_stat.invalid   = r_invalid;
    assign o_stat.peak_zero = (r_peak == 16'd0);
    assign o_stat.out_free  = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !full) begin
            mem[r_count[BUF_AW-1:0]] <= n_env;
        end
        r_rd <= mem[r_i[BUF_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs      <= 18'd48000;
            r_coef    <= 16'd65501;
            r_on      <= 16'd0;
            r_off     <= 16'd0;
            r_onset   <= 16'd0;
            r_count   <= '0;
            r_env     <= 16'd0;
            r_done    <= 1'b0;
            r_ph      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SAMPLE_RATE: r_fs    <= i_cfg_data;
                    CFG_RELEASE:     r_coef  <= i_cfg_data[15:0];
                    CFG_NOTE_ON:     r_on    <= i_cfg_data[15:0];
                    CFG_NOTE_OFF:    r_off   <= i_cfg_data[15:0];
                    CFG_ONSET:       r_onset <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_last_sample) begin
                    r_count <= '0;
                    r_env   <= 16'd0;
                end else if (!full) begin
                    r_env   <= n_env;
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.op == OP_LOAD) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_PEAK_INIT, OP_ATK_INIT, OP_SUS_INIT, OP_DIV_INIT,
                OP_DEC_INIT, OP_REL_INIT: begin
                    r_done <= 1'b0;
                    r_ph   <= 1'b0;
                end
                OP_RUN: begin
                    if (!r_done) begin
                        if (!r_ph) begin
                            if (r_i >= r_lim) r_done <= 1'b1;
                            else r_ph <= 1'b1;
                        end else begin
                            r_ph <= 1'b0;
                            case (r_pass)
                                P_ATK: if (r_found && r_rd < r_prev) r_done <= 1'b1;
                                P_DEC: if (e100 <= r_tgt) r_done <= 1'b1;
                                P_REL: begin
                                    if (r_rd == 16'd0 || e100 <= 22'(r_s4)) r_done <= 1'b1;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                OP_DIV_RUN: if (r_dcnt == 6'd32) r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last_sample) begin
            r_n <= full ? r_count : r_count + CNT_W'(1);
        end
        unique case (i_cmd.op)
            OP_SETUP1: begin
                r_fs50    <= p50[35:24];
                r_fs10    <= p10[38:24];
                r_invalid <= (r_n == '0) || (r_fs == 18'd0) || (r_off <= r_on);
                r_gate    <= (22'(16'(r_off - r_on)) * 22'd25) >= (22'(r_fs) * 22'd3);
            end
            OP_SETUP2: begin
                r_ss <= n_ss;
                r_se <= n_se;
            end
            OP_PEAK_INIT: begin
                r_i    <= r_ss;
                r_lim  <= r_se;
                r_peak <= 16'd0;
                r_pass <= P_PEAK;
            end
            OP_ATK_INIT: begin
                r_i     <= r_ss;
                r_lim   <= r_se;
                r_pk    <= r_ss;
                r_found <= 1'b0;
                r_p97   <= 22'(r_peak) * 22'd97;
                r_pass  <= P_ATK;
            end
            OP_CALC1: begin
                r_margin <= (CNT_W'(r_off) > r_pk) ? 16'(CNT_W'(r_off) - r_pk) : 16'd0;
                r_sus    <= r_peak;
            end
            OP_CALC2: begin
                r_sus_seen <= r_gate &&
                    ((24'(r_margin) * 24'd25) >= (24'(r_fs) * 24'd2));
                r_dec_seen <= (24'(r_margin) * 24'd200) >= (24'(r_fs) * 24'd3);
                r_w2       <= p5[35:20];
            end
            OP_CALC3: begin
                r_st <= (r_off > w_min) ? CNT_W'(r_off - w_min) : r_pk;
            end
            OP_SUS_INIT: begin
                r_i    <= r_st;
                r_lim  <= r_sus_seen ? off_n : r_st;
                r_sum  <= 32'd0;
                r_cnt  <= '0;
                r_pass <= P_SUS;
            end
            OP_DIV_INIT: begin
                r_quo  <= r_sum;
                r_rem  <= 18'd0;
                r_dcnt <= 6'd0;
            end
            OP_DIV_RUN: begin
                if (r_dcnt == 6'd32) begin
                    if (r_cnt != '0) r_sus <= r_quo[15:0];
                end else begin
                    r_dcnt <= r_dcnt + 6'd1;
                    if (rem_sh >= 18'(r_cnt)) begin
                        r_rem <= rem_sh - 18'(r_cnt);
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                end
            end
            OP_DEC_INIT: begin
                r_i    <= r_pk;
                r_lim  <= r_dec_seen ? off_n : r_pk;
                r_dec  <= 16'd0;
                r_tgt  <= 22'(r_sus) * 22'd97 + 22'(r_peak) * 22'd3;
                r_pass <= P_DEC;
            end
            OP_REL_INIT: begin
                r_i    <= n_rs;
                r_rs   <= n_rs;
                r_lim  <= r_n;
                r_re   <= r_n;
                r_s4   <= {r_sus, 2'b00};
                r_pass <= P_REL;
            end
            OP_RUN: begin
                if (!r_done && r_ph) begin
                    r_i <= r_i + CNT_W'(1);
                    case (r_pass)
                        P_PEAK: if (r_rd > r_peak) r_peak <= r_rd;
                        P_ATK: begin
                            if (!r_found) begin
                                if (e100 >= r_p97) begin
                                    r_found <= 1'b1;
                                    r_pk    <= r_i;
                                    r_prev  <= r_rd;
                                end
                            end else if (r_rd >= r_prev) begin
                                r_pk   <= r_i;
                                r_prev <= r_rd;
                            end
                        end
                        P_SUS: begin
                            r_sum <= r_sum + 32'(r_rd);
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        P_DEC: if (e100 <= r_tgt) r_dec <= 16'(r_i - r_pk);
                        P_REL: if (r_rd == 16'd0 || e100 <= 22'(r_s4)) r_re <= r_i;
                        default: ;
                    endcase
                end
            end
            OP_LOAD: begin
                r_o_status   <= r_invalid ? ST_INVALID : (out_ok ? ST_OK : ST_ZERO);
                r_o_peak     <= out_ok ? r_peak : 16'd0;
                r_o_attack   <= out_ok ? 16'(r_pk - r_ss) : 16'd0;
                r_o_sus_seen <= out_ok && r_sus_seen;
                r_o_sus      <= out_ok ? r_sus : 16'd0;
                r_o_dec_seen <= out_ok && r_dec_seen;
                r_o_dec      <= out_ok ? r_dec : 16'd0;
                r_o_rel      <= out_ok ? 17'(r_re - r_rs) : 17'd0;
            end
            default: ;
        endcase
    end

    assign o_out_valid       = r_o_valid;
    assign o_status          = r_o_status;
    assign o_peak_level      = r_o_peak;
    assign o_attack_samples  = r_o_attack;
    assign o_sustain_seen    = r_o_sus_seen;
    assign o_sustain_level   = r_o_sus;
    assign o_decay_seen      = r_o_dec_seen;
    assign o_decay_samples   = r_o_dec;
    assign o_release_samples = r_o_rel;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUFFER_DEPTH))
        else $error("sample count beyond buffer depth");

    a_attack_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_RUN && r_pass == P_ATK && r_done) |-> r_found)
        else $error("attack pass ended without a point at 97 percent of peak");

    a_mean_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV_RUN && r_dcnt == 6'd32 && r_cnt != '0)
        |-> (r_quo[31:16] == 16'd0))
        else $error("sustain mean exceeds level range");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_LOAD) |=> r_o_valid)
        else $error("result not presented after load");

endmodule
`default_nettype wire

/* sv/adsrem_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module adsrem_ctrl import adsrem_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_last_sample,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SETUP1 = 5'd1;
    localparam logic [4:0] S_SETUP2 = 5'd2;
    localparam logic [4:0] S_PEAK_I = 5'd3;
    localparam logic [4:0] S_PEAK   = 5'd4;
    localparam logic [4:0] S_ATK_I  = 5'd5;
    localparam logic [4:0] S_ATK    = 5'd6;
    localparam logic [4:0] S_CALC1  = 5'd7;
    localparam logic [4:0] S_CALC2  = 5'd8;
    localparam logic [4:0] S_CALC3  = 5'd9;
    localparam logic [4:0] S_SUS_I  = 5'd10;
    localparam logic [4:0] S_SUS    = 5'd11;
    localparam logic [4:0] S_DIV_I  = 5'd12;
    localparam logic [4:0] S_DIV    = 5'd13;
    localparam logic [4:0] S_DEC_I  = 5'd14;
    localparam logic [4:0] S_DEC    = 5'd15;
    localparam logic [4:0] S_REL_I  = 5'd16;
    localparam logic [4:0] S_REL    = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = i_in_valid && o_in_ready;
        o_cmd.op     = OP_NONE;
        unique case (r_state)
            S_IDLE:   if (i_in_valid && i_last_sample) n_state = S_SETUP1;
            S_SETUP1: begin o_cmd.op = OP_SETUP1; n_state = S_SETUP2; end
            S_SETUP2: begin
                o_cmd.op = OP_SETUP2;
                n_state  = i_stat.invalid ? S_OUT : S_PEAK_I;
            end
            S_PEAK_I: begin o_cmd.op = OP_PEAK_INIT; n_state = S_PEAK; end
            S_PEAK: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = i_stat.peak_zero ? S_OUT : S_ATK_I;
            end
            S_ATK_I:  begin o_cmd.op = OP_ATK_INIT; n_state = S_ATK; end
            S_ATK: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = S_CALC1;
            end
            S_CALC1:  begin o_cmd.op = OP_CALC1; n_state = S_CALC2; end
            S_CALC2:  begin o_cmd.op = OP_CALC2; n_state = S_CALC3; end
            S_CALC3:  begin o_cmd.op = OP_CALC3; n_state = S_SUS_I; end
            S_SUS_I:  begin o_cmd.op = OP_SUS_INIT; n_state = S_SUS; end
            S_SUS: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = S_DIV_I;
            end
            S_DIV_I:  begin o_cmd.op = OP_DIV_INIT; n_state = S_DIV; end
            S_DIV: begin
                o_cmd.op = OP_DIV_RUN;
                if (i_stat.done) n_state = S_DEC_I;
            end
            S_DEC_I:  begin o_cmd.op = OP_DEC_INIT; n_state = S_DEC; end
            S_DEC: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = S_REL_I;
            end
            S_REL_I:  begin o_cmd.op = OP_REL_INIT; n_state = S_REL; end
            S_REL: begin
                o_cmd.op = OP_RUN;
                if (i_stat.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* sv/adsr_envelope_measurement.sv */
`timescale 1ns / 1ps
`default_nettype none
// Peak-envelope ADSR measurement. While idle the block takes one sample per
// clock, runs the peak follower and stores each envelope value in a 64K x 16
// buffer. The sample marked last closes the buffer of n samples; input ready
// then drops while a sequencer scans the buffer through its single read
// port, with a read phase and an evaluate phase for each entry: peak, attack,
// sustain mean, decay and release passes, plus a 32-step divider for the
// mean. A result waiting at the output does not block new samples.
module adsr_envelope_measurement import adsrem_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [15:0]       i_sample,
    input  wire logic              i_last_sample,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_status,
    output logic [15:0]            o_peak_level,
    output logic [15:0]            o_attack_samples,
    output logic                   o_sustain_seen,
    output logic [15:0]            o_sustain_level,
    output logic                   o_decay_seen,
    output logic [15:0]            o_decay_samples,
    output logic [16:0]            o_release_samples
);

    t_cmd  cmd;
    t_stat stat;

    adsrem_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_last_sample),
        .o_in_ready    (o_in_ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    adsrem_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_sample          (i_sample),
        .i_last_sample     (i_last_sample),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_peak_level      (o_peak_level),
        .o_attack_samples  (o_attack_samples),
        .o_sustain_seen    (o_sustain_seen),
        .o_sustain_level   (o_sustain_level),
        .o_decay_seen      (o_decay_seen),
        .o_decay_samples   (o_decay_samples),
        .o_release_samples (o_release_samples)
    );

endmodule
`default_nettype wire
